### sv/multi_slot_timeout_monitor_assert.svh
// assertion macros for the multi-slot timeout monitor
// no dependencies; taken in by the top level
`ifndef MULTI_SLOT_TIMEOUT_MONITOR_ASSERT_SVH
`define MULTI_SLOT_TIMEOUT_MONITOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MSTM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define MSTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define MSTM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MSTM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/mstm_pkg.sv
// shared types and constants for the multi-slot timeout monitor
// no dependencies
package mstm_pkg;

   localparam int NUM_SLOTS_DEF = 16;
   localparam int SLOT_W        = 4;
   localparam int TIME_W        = 32;
   localparam int MASK_W        = 16;
   localparam logic [TIME_W-1:0] TICK_STEP = 32'd1;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_ADD    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_KICK   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_INVALID   = 2'd1,
      STATUS_NOT_ARMED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST
   } state_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] period;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [MASK_W-1:0] expired_mask;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic valid;
      logic armed;
   } scan_ctl_type;

endpackage

### sv/mstm_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mstm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### sv/mstm_expiry.sv
// shared expiry compare unit: one slot per cycle, accumulates the expired mask
// depends on mstm_pkg
module mstm_expiry #(
   parameter int IDX_W = 4
) (
   input  logic                        clock,
   input  mstm_pkg::scan_ctl_type      ctl,
   input  logic [IDX_W-1:0]            idx,
   input  logic [mstm_pkg::TIME_W-1:0] tick_count,
   input  logic [mstm_pkg::TIME_W-1:0] stamp,
   input  logic [mstm_pkg::TIME_W-1:0] period,
   output logic [mstm_pkg::MASK_W-1:0] mask_next
);
   import mstm_pkg::*;

   logic [MASK_W-1:0] mask_ff;
   logic [MASK_W-1:0] mask_in;
   logic [TIME_W-1:0] age;
   logic              hit;

   always_comb begin
      age       = tick_count - stamp;
      hit       = ctl.valid && ctl.armed && (age > period);
      mask_next = hit ? (mask_ff | (MASK_W'(1) << idx)) : mask_ff;
      if (ctl.clear) begin
         mask_in = '0;
      end else begin
         mask_in = mask_next;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
   end
endmodule

### sv/multi_slot_timeout_monitor.sv
// top level of the multi-slot timeout monitor: sequencer, slot flags, tick counter
// depends on mstm_pkg, mstm_ram, mstm_expiry and multi_slot_timeout_monitor_assert.svh
//
//   channel   handshake            payload
//   request   start / busy         req_item (opcode, slot, period)
//   response  rsp_strobe           rsp_item (status, expired_mask)
//
// add, remove and kick: result in the cycle after acceptance, block free again at once.
// tick: the compare unit walks the first min(NUM_SLOTS,16) slots one entry a cycle;
//   busy stays high until the result, which is shown in the cycle that busy falls.
// reset clears the slot flags, the tick counter and the sequencer; the stamp and
//   period memories are not cleared, and their contents count only for armed slots.
// the result is shown for one cycle and cannot be held off.
`include "multi_slot_timeout_monitor_assert.svh"

module multi_slot_timeout_monitor #(
   parameter int NUM_SLOTS = mstm_pkg::NUM_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mstm_pkg::req_type req_item,
   output logic              rsp_strobe,
   output mstm_pkg::rsp_type rsp_item
);
   import mstm_pkg::*;

   localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SCAN_N = (NUM_SLOTS < MASK_W) ? NUM_SLOTS : MASK_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_N - 1);

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [NUM_SLOTS-1:0] armed_ff, armed_in;
   logic [TIME_W-1:0]  tick_ff, tick_in;
   logic               strobe_ff, strobe_in;
   rsp_type            rsp_ff, rsp_in;

   logic               stamp_we;
   logic               period_we;
   logic [IDX_W-1:0]   wr_idx;
   logic               slot_ok;
   logic [TIME_W-1:0]  stamp_rd;
   logic [TIME_W-1:0]  period_rd;
   logic [MASK_W-1:0]  mask_next;
   scan_ctl_type       scan_ctl;

   assign wr_idx  = IDX_W'(req_item.slot);
   assign slot_ok = (32'(req_item.slot) < 32'(NUM_SLOTS));
   assign busy    = (state_ff != ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      scan_idx_in    = scan_idx_ff;
      cmp_idx_in     = scan_idx_ff;
      rd_pend_in     = 1'b0;
      armed_in       = armed_ff;
      tick_in        = tick_ff;
      strobe_in      = 1'b0;
      rsp_in         = rsp_ff;
      stamp_we       = 1'b0;
      period_we      = 1'b0;
      scan_ctl.clear = 1'b0;
      scan_ctl.valid = rd_pend_ff;
      scan_ctl.armed = armed_ff[cmp_idx_ff];
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_item.opcode == OP_TICK) begin
                  scan_ctl.clear = 1'b1;
                  scan_idx_in    = '0;
                  state_in       = ST_SCAN;
               end else begin
                  strobe_in           = 1'b1;
                  rsp_in.expired_mask = '0;
                  rsp_in.status       = STATUS_OK;
                  if (!slot_ok) begin
                     rsp_in.status = STATUS_INVALID;
                  end else begin
                     case (req_item.opcode)
                        OP_ADD: begin
                           if (req_item.period == '0) begin
                              rsp_in.status = STATUS_INVALID;
                           end else begin
                              stamp_we         = 1'b1;
                              period_we        = 1'b1;
                              armed_in[wr_idx] = 1'b1;
                           end
                        end
                        OP_REMOVE: begin
                           if (armed_ff[wr_idx]) begin
                              armed_in[wr_idx] = 1'b0;
                           end else begin
                              rsp_in.status = STATUS_NOT_ARMED;
                           end
                        end
                        OP_KICK: begin
                           stamp_we = 1'b1;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
         end
         ST_SCAN: begin
            rd_pend_in = 1'b1;
            cmp_idx_in = scan_idx_ff;
            if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_LAST;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         ST_LAST: begin
            strobe_in           = 1'b1;
            rsp_in.status       = STATUS_OK;
            rsp_in.expired_mask = mask_next;
            tick_in             = tick_ff + TICK_STEP;
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_pend_ff <= 1'b0;
         armed_ff   <= '0;
         tick_ff    <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_pend_in;
         armed_ff   <= armed_in;
         tick_ff    <= tick_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      rsp_ff      <= rsp_in;
   end

   mstm_ram #(
      .WIDTH(TIME_W),
      .DEPTH(NUM_SLOTS)
   ) u_stamp_ram (
      .clock  (clock),
      .wr_en  (stamp_we),
      .wr_addr(wr_idx),
      .wr_data(tick_ff),
      .rd_addr(scan_idx_ff),
      .rd_data(stamp_rd)
   );

   mstm_ram #(
      .WIDTH(TIME_W),
      .DEPTH(NUM_SLOTS)
   ) u_period_ram (
      .clock  (clock),
      .wr_en  (period_we),
      .wr_addr(wr_idx),
      .wr_data(req_item.period),
      .rd_addr(scan_idx_ff),
      .rd_data(period_rd)
   );

   mstm_expiry #(
      .IDX_W(IDX_W)
   ) u_expiry (
      .clock     (clock),
      .ctl       (scan_ctl),
      .idx       (cmp_idx_ff),
      .tick_count(tick_ff),
      .stamp     (stamp_rd),
      .period    (period_rd),
      .mask_next (mask_next)
   );

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   `MSTM_ASSERT_IMPL(a_no_result_while_busy, clock, reset, busy, !rsp_strobe)
   `MSTM_ASSERT_NEXT(a_tick_goes_busy, clock, reset,
      start && !busy && (req_item.opcode == OP_TICK), busy)
   `MSTM_ASSERT_NEXT(a_slot_op_result, clock, reset,
      start && !busy && (req_item.opcode != OP_TICK),
      rsp_strobe && (rsp_item.expired_mask == '0))
   `MSTM_ASSERT_IMPL(a_scan_end_result, clock, reset, $fell(busy),
      rsp_strobe && (rsp_item.status == STATUS_OK))
endmodule

### verif/multi_slot_timeout_monitor_test.sv
// self-checking bench for multi_slot_timeout_monitor: directed and random slot commands,
// each result checked against an in-bench watchdog table with its own tick counter
// depends on mstm_pkg and the multi_slot_timeout_monitor rtl
module multi_slot_timeout_monitor_test;
   import mstm_pkg::*;

   localparam int SLOTS = NUM_SLOTS_DEF;

   typedef struct {
      req_type     item;
      int unsigned gap;
      bit          drain;
   } cmd_slot_type;

   logic    clock;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   multi_slot_timeout_monitor u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // watchdog table as the bench sees it
   logic [TIME_W-1:0] tick_now;
   logic [SLOTS-1:0]  armed;
   logic [TIME_W-1:0] stamp  [SLOTS];
   logic [TIME_W-1:0] period [SLOTS];

   cmd_slot_type cmd_q[$];
   rsp_type      verdict_q[$];
   cmd_slot_type nxt;
   bit           have_next;
   int unsigned  gap_left;
   int unsigned  outstanding;
   int unsigned  issued;
   int unsigned  ticks_sent;
   int unsigned  checked;
   int unsigned  expired_seen;
   int unsigned  mismatch_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("multi_slot_timeout_monitor verification failed");
      $finish;
   end

   task automatic apply_watchdog_cmd(input req_type cmd);
      rsp_type     v;
      int unsigned idx;
      v.status       = STATUS_OK;
      v.expired_mask = '0;
      idx            = 32'(cmd.slot);
      if (cmd.opcode == OP_TICK) begin
         for (int i = 0; i < SLOTS && i < MASK_W; i++) begin
            if (armed[i] && (tick_now - stamp[i]) > period[i]) v.expired_mask[i] = 1'b1;
         end
         tick_now = tick_now + TICK_STEP;
      end else if (idx >= SLOTS) begin
         v.status = STATUS_INVALID;
      end else begin
         case (cmd.opcode)
            OP_ADD: begin
               if (cmd.period == '0) begin
                  v.status = STATUS_INVALID;
               end else begin
                  stamp[idx]  = tick_now;
                  period[idx] = cmd.period;
                  armed[idx]  = 1'b1;
               end
            end
            OP_REMOVE: begin
               if (armed[idx]) armed[idx] = 1'b0;
               else v.status = STATUS_NOT_ARMED;
            end
            default: stamp[idx] = tick_now;
         endcase
      end
      verdict_q.push_back(v);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s at %0t: expected %h, got %h", what, $time, want, got);
   endtask

   function automatic req_type make_cmd(input opcode_type op, input int unsigned slot,
                                        input logic [TIME_W-1:0] per);
      req_type r;
      r.opcode = op;
      r.slot   = slot[SLOT_W-1:0];
      r.period = per;
      return r;
   endfunction

   task automatic queue_cmd(input req_type r, input int unsigned gap, input bit drain);
      cmd_slot_type c;
      c.item  = r;
      c.gap   = gap;
      c.drain = drain;
      cmd_q.push_back(c);
   endtask

   // driver: one item presented at a time, held until busy is low
   always @(posedge clock) begin
      if (reset) begin
         start       <= 1'b0;
         have_next    = 1'b0;
         gap_left     = 0;
         outstanding  = 0;
         tick_now     = '0;
         armed        = '0;
      end else begin
         if (rsp_strobe) outstanding--;
         if (start && !busy) begin
            apply_watchdog_cmd(req_item);
            outstanding++;
            issued++;
            if (req_item.opcode == OP_TICK) ticks_sent++;
         end
         if (!start || !busy) begin
            if (!have_next && cmd_q.size() > 0) begin
               nxt       = cmd_q.pop_front();
               have_next = 1'b1;
               gap_left  = nxt.gap;
            end
            if (have_next && gap_left == 0 && !(nxt.drain && outstanding != 0)) begin
               start     <= 1'b1;
               req_item  <= nxt.item;
               have_next  = 1'b0;
            end else begin
               start <= 1'b0;
               if (have_next && gap_left > 0) gap_left--;
            end
         end
      end
   end

   // monitor: every strobed result against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (verdict_q.size() == 0) begin
            report_mismatch("unexpected result", '0, 32'(rsp_item));
         end else begin
            want = verdict_q.pop_front();
            checked++;
            if (rsp_item.expired_mask != '0) expired_seen++;
            if (rsp_item.status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_item.status));
            if (rsp_item.expired_mask !== want.expired_mask)
               report_mismatch("expired_mask", 32'(want.expired_mask),
                               32'(rsp_item.expired_mask));
         end
      end
   end

   initial begin
      logic [TIME_W-1:0] per;
      opcode_type        op;
      bit                calm;
      int unsigned       pick;

      // directed: bad period, unarmed remove and kick, expiry, repeat, kick, rearm
      queue_cmd(make_cmd(OP_TICK, 15, 32'hFFFF_FFFF), 0, 1'b0);
      queue_cmd(make_cmd(OP_ADD, 0, 32'h0), 3, 1'b0);
      queue_cmd(make_cmd(OP_REMOVE, 3, 32'h0), 0, 1'b0);
      queue_cmd(make_cmd(OP_KICK, 5, 32'h0), 1, 1'b0);
      queue_cmd(make_cmd(OP_ADD, 0, 32'h1), 0, 1'b0);
      queue_cmd(make_cmd(OP_ADD, 15, 32'hFFFF_FFFF), 0, 1'b0);
      queue_cmd(make_cmd(OP_ADD, 9, 32'h2), 2, 1'b0);
      repeat (4) queue_cmd(make_cmd(OP_TICK, 0, 32'h0), 0, 1'b0);
      queue_cmd(make_cmd(OP_KICK, 0, 32'h0), 0, 1'b0);
      queue_cmd(make_cmd(OP_TICK, 7, 32'h5555_5555), 4, 1'b0);
      queue_cmd(make_cmd(OP_ADD, 0, 32'h5), 0, 1'b0);
      queue_cmd(make_cmd(OP_REMOVE, 15, 32'h0), 0, 1'b0);
      queue_cmd(make_cmd(OP_REMOVE, 15, 32'hFFFF_FFFF), 0, 1'b0);
      queue_cmd(make_cmd(OP_KICK, 9, 32'h0), 0, 1'b0);
      queue_cmd(make_cmd(OP_TICK, 10, 32'hAAAA_AAAA), 0, 1'b0);
      queue_cmd(make_cmd(OP_ADD, 10, 32'h8000_0000), 0, 1'b0);
      queue_cmd(make_cmd(OP_ADD, 5, 32'h7FFF_FFFF), 0, 1'b0);
      queue_cmd(make_cmd(OP_TICK, 0, 32'h0), 6, 1'b1);
      queue_cmd(make_cmd(OP_TICK, 0, 32'h0), 0, 1'b0);

      // random: small periods so slots expire, large ones and bad ones mixed in
      calm = 1'b0;
      for (int n = 0; n < 1325; n++) begin
         if (n % 50 == 0) calm = ($urandom_range(0, 2) == 0);
         pick = $urandom_range(0, 19);
         if (pick < 8) op = OP_TICK;
         else if (pick < 12) op = OP_ADD;
         else if (pick < 15) op = OP_REMOVE;
         else op = OP_KICK;
         case ($urandom_range(0, 9))
            0:       per = '0;
            1, 2:    per = $urandom();
            default: per = $urandom_range(1, 24);
         endcase
         queue_cmd(make_cmd(op, $urandom_range(0, 15), per),
                   calm ? 0 : $urandom_range(0, 9), (n % 250 == 125));
      end

      // hold reset, then release it
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (reset) @(negedge clock);
      while (cmd_q.size() != 0 || have_next || start || outstanding != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (verdict_q.size() != 0) begin
         $display("%0d expected results never arrived", verdict_q.size());
         mismatch_count += verdict_q.size();
      end
      $display("%0d items sent, %0d of them ticks; %0d results checked, %0d with expired slots",
               issued, ticks_sent, checked, expired_seen);
      if (mismatch_count == 0) begin
         $display("multi_slot_timeout_monitor verification clean");
      end else begin
         $display("multi_slot_timeout_monitor verification failed");
      end
      $finish;
   end

endmodule
